// ===== hdl/ellipse_span_rasterizer_top_assert.svh =====
// assertion macros for the ellipse span rasterizer
// included by ellipse_span_rasterizer_top, no other dependencies
`ifndef ELLIPSE_SPAN_RASTERIZER_TOP_ASSERT_SVH
`define ELLIPSE_SPAN_RASTERIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ESR_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("esr check failed: same cycle");
`define ESR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("esr check failed: next cycle");
`else
`define ESR_ASSERT_NOW(label, clk, rst, pre, post)
`define ESR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/esr_pkg.sv =====
// shared types and microcode table of the ellipse span rasterizer
// no dependencies
package esr_pkg;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MUL_A  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DIV_A  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_CAP_A  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MUL_B  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIV_B  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CAP_B  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_EMIT_0 = 4'd7;
   localparam logic [STEP_W-1:0] STEP_EMIT_1 = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EMIT_2 = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT_3 = 4'd10;
   localparam logic [STEP_W-1:0] STEP_ONE    = 4'd11;
   localparam logic [STEP_W-1:0] STEP_NULL   = 4'd12;

   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_SPAN = 2'd1,
      EMIT_ONE  = 2'd2,
      EMIT_NULL = 2'd3
   } emit_type;

   typedef struct packed {
      logic     accept;     // take an input item, then dispatch
      logic     mul_go;     // register operand times minor radius
      logic     sel_minor;  // operand is vi (else ui), result goes to b (else a)
      logic     div_go;     // start the divider on the product
      logic     div_wait;   // hold until the quotient is ready, then capture it
      emit_type emit;
      logic [1:0] span_idx;
      logic     commit;     // apply the midpoint step when the span leaves
      logic     go_home;
   } uword_type;

   function automatic uword_type ucode(logic [STEP_W-1:0] step);
      uword_type w;
      w = '0;
      unique case (step)
         STEP_WAIT:   w.accept = 1'b1;
         STEP_MUL_A:  w.mul_go = 1'b1;
         STEP_DIV_A:  w.div_go = 1'b1;
         STEP_CAP_A:  w.div_wait = 1'b1;
         STEP_MUL_B: begin
            w.mul_go    = 1'b1;
            w.sel_minor = 1'b1;
         end
         STEP_DIV_B:  w.div_go = 1'b1;
         STEP_CAP_B: begin
            w.div_wait  = 1'b1;
            w.sel_minor = 1'b1;
         end
         STEP_EMIT_0: begin
            w.emit     = EMIT_SPAN;
            w.span_idx = 2'd0;
         end
         STEP_EMIT_1: begin
            w.emit     = EMIT_SPAN;
            w.span_idx = 2'd1;
         end
         STEP_EMIT_2: begin
            w.emit     = EMIT_SPAN;
            w.span_idx = 2'd2;
         end
         STEP_EMIT_3: begin
            w.emit     = EMIT_SPAN;
            w.span_idx = 2'd3;
            w.commit   = 1'b1;
            w.go_home  = 1'b1;
         end
         STEP_ONE: begin
            w.emit    = EMIT_ONE;
            w.go_home = 1'b1;
         end
         STEP_NULL: begin
            w.emit    = EMIT_NULL;
            w.go_home = 1'b1;
         end
         default:     w.go_home = 1'b1;
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/esr_divider.sv =====
// restoring divider, one quotient bit per cycle, for the ellipse span rasterizer
// quotient must fit RADIUS_BITS (numerator high half below the divisor); no dependencies
module esr_divider #(
   parameter int RADIUS_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2*RADIUS_BITS-1:0] numerator,
   input  logic [RADIUS_BITS-1:0]   divisor,
   output logic                     busy,
   output logic [RADIUS_BITS-1:0]   quotient
);

   localparam int CNT_W = $clog2(RADIUS_BITS + 1);

   logic [RADIUS_BITS-1:0] rem_ff, rem_in;
   logic [RADIUS_BITS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [RADIUS_BITS:0]   shifted;
   logic [RADIUS_BITS+1:0] trial;

   assign shifted = {rem_ff, quo_ff[RADIUS_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = numerator[2*RADIUS_BITS-1:RADIUS_BITS];
         quo_in = numerator[RADIUS_BITS-1:0];
         cnt_in = CNT_W'(RADIUS_BITS);
      end else if (cnt_ff != '0) begin
         // borrow set means the divisor does not fit
         if (trial[RADIUS_BITS+1]) begin
            rem_in = shifted[RADIUS_BITS-1:0];
            quo_in = {quo_ff[RADIUS_BITS-2:0], 1'b0};
         end else begin
            rem_in = trial[RADIUS_BITS-1:0];
            quo_in = {quo_ff[RADIUS_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// ===== hdl/ellipse_span_rasterizer_top.sv =====
// Ellipse span rasterizer: fills an axis-aligned ellipse in one grid plane with horizontal
// spans, using midpoint circle stepping on the larger radius and scaling the smaller one by
// an integer division. A start item loads the job and emits the four spans of the first
// iteration; each next item emits four more, and last_span marks the end. Both radii zero
// gives a single cell; a next item with no job gives one result with span_valid low. A
// microcode table sequences one multiplier and a shared restoring divider (esr_divider,
// one quotient bit a cycle) that runs twice per iteration. One item is worked on at a
// time, and results leave through an output register. Depends on esr_pkg and the
// assertion macro header.
`include "ellipse_span_rasterizer_top_assert.svh"
module ellipse_span_rasterizer_top #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [1:0]                   req_plane_axis,
   input  logic signed [COORD_BITS-1:0] req_center_u,
   input  logic signed [COORD_BITS-1:0] req_center_v,
   input  logic signed [COORD_BITS-1:0] req_plane_index,
   input  logic [RADIUS_BITS-1:0]       req_radius_u,
   input  logic [RADIUS_BITS-1:0]       req_radius_v,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_span_valid,
   output logic [1:0]                   rsp_span_axis,
   output logic signed [COORD_BITS:0]   rsp_span_u_lo,
   output logic signed [COORD_BITS:0]   rsp_span_u_hi,
   output logic signed [COORD_BITS:0]   rsp_span_row,
   output logic signed [COORD_BITS-1:0] rsp_span_plane,
   output logic                         rsp_last_span
);

   import esr_pkg::*;

   localparam int SPAN_W = COORD_BITS + 1;
   localparam int ERR_W  = RADIUS_BITS + 3;
   localparam int WIDE_W = SPAN_W + RADIUS_BITS + 1;

   // sequencer
   logic [STEP_W-1:0] step_ff, step_in;
   uword_type         cw;
   logic              hold;
   logic              out_free;
   logic              out_fire;
   logic              req_fire;
   logic              both_zero;

   // job state
   logic                         job_active_ff, job_active_in;
   logic                         major_u_ff;
   logic [RADIUS_BITS-1:0]       major_ff;
   logic [RADIUS_BITS-1:0]       minor_ff;
   logic [RADIUS_BITS-1:0]       ui_ff, ui_in;
   logic [RADIUS_BITS:0]         vi_ff, vi_in;
   logic signed [ERR_W-1:0]      ri_ff, ri_in;
   logic signed [COORD_BITS-1:0] cu_ff;
   logic signed [COORD_BITS-1:0] cv_ff;
   logic signed [COORD_BITS-1:0] plane_ff;
   logic [1:0]                   axis_ff;
   logic                         start_major_u;
   logic [RADIUS_BITS-1:0]       start_major;
   logic [RADIUS_BITS-1:0]       start_minor;

   // arithmetic
   logic [RADIUS_BITS-1:0]   mul_op;
   logic [2*RADIUS_BITS-1:0] prod_ff;
   logic                     div_busy;
   logic [RADIUS_BITS-1:0]   div_quo;
   logic [RADIUS_BITS-1:0]   a_ff;
   logic [RADIUS_BITS-1:0]   b_ff;

   // midpoint update
   logic signed [ERR_W-1:0] vi_twice;
   logic signed [ERR_W-1:0] err_dec;
   logic signed [ERR_W-1:0] ri_sub;
   logic signed [ERR_W-1:0] ui_less;
   logic                    take_step;
   logic [RADIUS_BITS-1:0]  ui_nx;
   logic [RADIUS_BITS:0]    vi_nx;
   logic signed [ERR_W-1:0] ri_nx;
   logic                    last_nx;

   // span geometry
   logic [RADIUS_BITS:0]  half_w;
   logic [RADIUS_BITS:0]  row_off;
   logic [WIDE_W-1:0]     half_wide;
   logic [WIDE_W-1:0]     off_wide;
   logic [SPAN_W-1:0]     half_s;
   logic [SPAN_W-1:0]     off_s;
   logic [SPAN_W-1:0]     cu_s;
   logic [SPAN_W-1:0]     cv_s;

   // output register
   logic                    out_valid_ff, out_valid_in;
   logic                    o_span_valid_ff, o_span_valid_in;
   logic [1:0]              o_axis_ff, o_axis_in;
   logic [SPAN_W-1:0]       o_lo_ff, o_lo_in;
   logic [SPAN_W-1:0]       o_hi_ff, o_hi_in;
   logic [SPAN_W-1:0]       o_row_ff, o_row_in;
   logic [COORD_BITS-1:0]   o_plane_ff, o_plane_in;
   logic                    o_last_ff, o_last_in;

   assign cw        = ucode(step_ff);
   assign req_stall = !cw.accept;
   assign req_fire  = req_valid && cw.accept;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign out_fire  = (cw.emit != EMIT_NONE) && out_free;
   assign both_zero = (req_radius_u == '0) && (req_radius_v == '0);

   assign hold = (cw.accept && !req_valid) || (cw.div_wait && div_busy) ||
                 ((cw.emit != EMIT_NONE) && !out_free);

   always_comb begin
      step_in = step_ff;
      if (!hold) begin
         priority if (cw.accept) begin
            if (req_operation == OP_START) begin
               step_in = both_zero ? STEP_ONE : STEP_MUL_A;
            end else begin
               step_in = job_active_ff ? STEP_MUL_A : STEP_NULL;
            end
         end else if (cw.go_home) begin
            step_in = STEP_WAIT;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   assign start_major_u = req_radius_u > req_radius_v;
   assign start_major   = start_major_u ? req_radius_u : req_radius_v;
   assign start_minor   = start_major_u ? req_radius_v : req_radius_u;

   // midpoint step on the major radius
   assign vi_twice = $signed({2'b00, vi_ff}) <<< 1;
   assign err_dec  = major_u_ff ? (vi_twice + ERR_W'(1)) : (vi_twice - ERR_W'(1));
   assign ri_sub   = ri_ff - err_dec;
   assign ui_less  = $signed({3'b000, ui_ff}) - ERR_W'(1);
   assign take_step = major_u_ff ? (ri_sub <= 0) : (ri_sub < 0);
   assign ri_nx    = take_step ? (ri_sub + (ui_less <<< 1)) : ri_sub;
   assign ui_nx    = take_step ? (ui_ff - 1'b1) : ui_ff;
   assign vi_nx    = vi_ff + 1'b1;
   assign last_nx  = {1'b0, ui_nx} < vi_nx;

   always_comb begin
      job_active_in = job_active_ff;
      ui_in = ui_ff;
      vi_in = vi_ff;
      ri_in = ri_ff;
      if (req_fire && (req_operation == OP_START)) begin
         job_active_in = !both_zero;
         ui_in = start_major;
         vi_in = '0;
         ri_in = $signed({3'b000, start_major});
      end else if (out_fire && cw.commit) begin
         job_active_in = !last_nx;
         ui_in = ui_nx;
         vi_in = vi_nx;
         ri_in = ri_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_WAIT;
         job_active_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         job_active_ff <= job_active_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ui_ff <= ui_in;
      vi_ff <= vi_in;
      ri_ff <= ri_in;
      if (req_fire && (req_operation == OP_START)) begin
         major_u_ff <= start_major_u;
         major_ff   <= start_major;
         minor_ff   <= start_minor;
         cu_ff      <= req_center_u;
         cv_ff      <= req_center_v;
         plane_ff   <= req_plane_index;
         axis_ff    <= req_plane_axis;
      end
   end

   // vi never exceeds ui while an iteration is being worked on
   assign mul_op = cw.sel_minor ? vi_ff[RADIUS_BITS-1:0] : ui_ff;

   always_ff @(posedge clock) begin
      if (cw.mul_go) begin
         prod_ff <= (2*RADIUS_BITS)'(mul_op) * (2*RADIUS_BITS)'(minor_ff);
      end
      if (cw.div_wait && !div_busy) begin
         if (cw.sel_minor) begin
            b_ff <= div_quo;
         end else begin
            a_ff <= div_quo;
         end
      end
   end

   esr_divider #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cw.div_go),
      .numerator(prod_ff),
      .divisor  (major_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // first pair of rows, then second pair; even index is the minus side
   always_comb begin
      if (major_u_ff) begin
         half_w  = cw.span_idx[1] ? vi_ff : {1'b0, ui_ff};
         row_off = cw.span_idx[1] ? {1'b0, a_ff} : {1'b0, b_ff};
      end else begin
         half_w  = cw.span_idx[1] ? {1'b0, b_ff} : {1'b0, a_ff};
         row_off = cw.span_idx[1] ? {1'b0, ui_ff} : vi_ff;
      end
   end

   assign half_wide = WIDE_W'(half_w);
   assign off_wide  = WIDE_W'(row_off);
   assign half_s    = half_wide[SPAN_W-1:0];
   assign off_s     = off_wide[SPAN_W-1:0];
   assign cu_s      = {cu_ff[COORD_BITS-1], cu_ff};
   assign cv_s      = {cv_ff[COORD_BITS-1], cv_ff};

   always_comb begin
      out_valid_in    = out_valid_ff && rsp_stall;
      o_span_valid_in = o_span_valid_ff;
      o_axis_in       = o_axis_ff;
      o_lo_in         = o_lo_ff;
      o_hi_in         = o_hi_ff;
      o_row_in        = o_row_ff;
      o_plane_in      = o_plane_ff;
      o_last_in       = o_last_ff;
      if (out_fire) begin
         out_valid_in = 1'b1;
         unique case (cw.emit)
            EMIT_SPAN: begin
               o_span_valid_in = 1'b1;
               o_axis_in       = axis_ff;
               o_lo_in         = cu_s - half_s;
               o_hi_in         = cu_s + half_s;
               o_row_in        = cw.span_idx[0] ? (cv_s + off_s) : (cv_s - off_s);
               o_plane_in      = plane_ff;
               o_last_in       = cw.commit && last_nx;
            end
            EMIT_ONE: begin
               o_span_valid_in = 1'b1;
               o_axis_in       = axis_ff;
               o_lo_in         = cu_s;
               o_hi_in         = cu_s;
               o_row_in        = cv_s;
               o_plane_in      = plane_ff;
               o_last_in       = 1'b1;
            end
            default: begin
               o_span_valid_in = 1'b0;
               o_axis_in       = '0;
               o_lo_in         = '0;
               o_hi_in         = '0;
               o_row_in        = '0;
               o_plane_in      = '0;
               o_last_in       = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      o_span_valid_ff <= o_span_valid_in;
      o_axis_ff       <= o_axis_in;
      o_lo_ff         <= o_lo_in;
      o_hi_ff         <= o_hi_in;
      o_row_ff        <= o_row_in;
      o_plane_ff      <= o_plane_in;
      o_last_ff       <= o_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_span_valid = o_span_valid_ff;
   assign rsp_span_axis  = o_axis_ff;
   assign rsp_span_u_lo  = $signed(o_lo_ff);
   assign rsp_span_u_hi  = $signed(o_hi_ff);
   assign rsp_span_row   = $signed(o_row_ff);
   assign rsp_span_plane = $signed(o_plane_ff);
   assign rsp_last_span  = o_last_ff;

   `ESR_ASSERT_NOW(a_div_not_restarted, clock, reset, cw.div_go, !div_busy)
   `ESR_ASSERT_NOW(a_step_order, clock, reset, job_active_ff && cw.accept, {1'b0, ui_ff} >= vi_ff)
   `ESR_ASSERT_NEXT(a_last_ends_job, clock, reset, out_fire && cw.commit && last_nx, !job_active_ff)

endmodule

// ===== dv/testbench.sv =====
// testbench for ellipse_span_rasterizer_top: directed table then random ellipse jobs,
// every result checked against an in-bench midpoint stepping predictor or a typed expected value
// depends on esr_pkg and ellipse_span_rasterizer_top
module testbench;
   import esr_pkg::*;

   localparam int COORD_W      = 12;
   localparam int RADIUS_W     = 10;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic                      span_valid;
      logic [1:0]                axis;
      logic signed [COORD_W:0]   u_lo;
      logic signed [COORD_W:0]   u_hi;
      logic signed [COORD_W:0]   row;
      logic signed [COORD_W-1:0] plane;
      logic                      last;
   } span_type;

   typedef struct {
      logic                      op;
      logic [1:0]                axis;
      logic signed [COORD_W-1:0] cu;
      logic signed [COORD_W-1:0] cv;
      logic signed [COORD_W-1:0] pw;
      logic [RADIUS_W-1:0]       ru;
      logic [RADIUS_W-1:0]       rv;
      bit                        typed;
      span_type                  want;
   } ellipse_req_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_operation = OP_START;
   logic [1:0]                req_plane_axis = 2'd0;
   logic signed [COORD_W-1:0] req_center_u = '0;
   logic signed [COORD_W-1:0] req_center_v = '0;
   logic signed [COORD_W-1:0] req_plane_index = '0;
   logic [RADIUS_W-1:0]       req_radius_u = '0;
   logic [RADIUS_W-1:0]       req_radius_v = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_span_valid;
   logic [1:0]                rsp_span_axis;
   logic signed [COORD_W:0]   rsp_span_u_lo;
   logic signed [COORD_W:0]   rsp_span_u_hi;
   logic signed [COORD_W:0]   rsp_span_row;
   logic signed [COORD_W-1:0] rsp_span_plane;
   logic                      rsp_last_span;

   ellipse_span_rasterizer_top #(
      .COORD_BITS (COORD_W),
      .RADIUS_BITS(RADIUS_W)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_plane_axis (req_plane_axis),
      .req_center_u   (req_center_u),
      .req_center_v   (req_center_v),
      .req_plane_index(req_plane_index),
      .req_radius_u   (req_radius_u),
      .req_radius_v   (req_radius_v),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_span_valid (rsp_span_valid),
      .rsp_span_axis  (rsp_span_axis),
      .rsp_span_u_lo  (rsp_span_u_lo),
      .rsp_span_u_hi  (rsp_span_u_hi),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_plane (rsp_span_plane),
      .rsp_last_span  (rsp_last_span)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // predictor copy of the rasterizer state
   bit                        job_busy;
   bit                        major_u;
   int                        step_u;
   int                        step_v;
   int                        err_acc;
   logic signed [COORD_W-1:0] held_cu;
   logic signed [COORD_W-1:0] held_cv;
   logic signed [COORD_W-1:0] held_pw;
   logic [RADIUS_W-1:0]       held_ru;
   logic [RADIUS_W-1:0]       held_rv;
   logic [1:0]                held_axis;

   span_type        predicted[$];
   span_type        spans_due[$];
   ellipse_req_type stim_rows[$];
   int              items_sent;
   int              rsp_count;
   int              mismatches;
   int              idle_cycles;
   bit              sender_quiet;
   bit              receiver_quiet;

   function automatic span_type span_at(longint lo, longint hi, longint row, bit last);
      span_type s;
      s.span_valid = 1'b1;
      s.axis       = held_axis;
      s.u_lo       = lo[COORD_W:0];
      s.u_hi       = hi[COORD_W:0];
      s.row        = row[COORD_W:0];
      s.plane      = held_pw;
      s.last       = last;
      return s;
   endfunction

   function automatic int scaled(int c, int minor, int major);
      if (major == 0 || c < 0) return 0;
      return (c * minor) / major;
   endfunction

   task automatic step_iteration();
      longint uc, vc;
      int     u0, v0, big, lesser, a, b;
      bit     done;
      uc     = held_cu;
      vc     = held_cv;
      u0     = step_u;
      v0     = step_v;
      big    = major_u ? int'(held_ru) : int'(held_rv);
      lesser = major_u ? int'(held_rv) : int'(held_ru);
      a      = scaled(step_u, lesser, big);
      b      = scaled(step_v, lesser, big);
      // midpoint update differs between the two orientations (decrement 2v+1 versus 2v-1, and <= versus <)
      if (major_u) begin
         err_acc -= 2 * step_v + 1;
         step_v++;
         if (err_acc <= 0) begin
            err_acc += 2 * (step_u - 1);
            step_u--;
         end
      end else begin
         err_acc -= 2 * step_v - 1;
         step_v++;
         if (err_acc < 0) begin
            err_acc += 2 * (step_u - 1);
            step_u--;
         end
      end
      done = step_u < step_v;
      if (done) job_busy = 1'b0;
      if (major_u) begin
         predicted.push_back(span_at(uc - u0, uc + u0, vc - b, 1'b0));
         predicted.push_back(span_at(uc - u0, uc + u0, vc + b, 1'b0));
         predicted.push_back(span_at(uc - v0, uc + v0, vc - a, 1'b0));
         predicted.push_back(span_at(uc - v0, uc + v0, vc + a, done));
      end else begin
         predicted.push_back(span_at(uc - a, uc + a, vc - v0, 1'b0));
         predicted.push_back(span_at(uc - a, uc + a, vc + v0, 1'b0));
         predicted.push_back(span_at(uc - b, uc + b, vc - u0, 1'b0));
         predicted.push_back(span_at(uc - b, uc + b, vc + u0, done));
      end
   endtask

   task automatic predict_spans(ellipse_req_type r);
      predicted.delete();
      if (r.op == OP_START) begin
         held_axis = r.axis;
         held_cu   = r.cu;
         held_cv   = r.cv;
         held_pw   = r.pw;
         held_ru   = r.ru;
         held_rv   = r.rv;
         major_u   = r.ru > r.rv;
         step_u    = major_u ? int'(r.ru) : int'(r.rv);
         err_acc   = step_u;
         step_v    = 0;
         if (step_u == 0) begin
            job_busy = 1'b0;
            predicted.push_back(span_at(held_cu, held_cu, held_cv, 1'b1));
         end else begin
            job_busy = 1'b1;
            step_iteration();
         end
      end else if (!job_busy) begin
         predicted.push_back('0);
      end else begin
         step_iteration();
      end
   endtask

   function automatic ellipse_req_type mk_row(logic op, int axis, int cu, int cv,
                                              int pw, int ru, int rv);
      ellipse_req_type r;
      r.op    = op;
      r.axis  = axis[1:0];
      r.cu    = cu[COORD_W-1:0];
      r.cv    = cv[COORD_W-1:0];
      r.pw    = pw[COORD_W-1:0];
      r.ru    = ru[RADIUS_W-1:0];
      r.rv    = rv[RADIUS_W-1:0];
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic ellipse_req_type mk_typed(ellipse_req_type r, span_type want);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic int rand_radius();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, (1 << RADIUS_W) - 1);
         1: return 0;
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   function automatic ellipse_req_type rand_row(logic op);
      ellipse_req_type r;
      r = mk_row(op, $urandom_range(0, 3), $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), rand_radius(), rand_radius());
      if ($urandom_range(0, 7) == 0) r.rv = r.ru;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("result %0d: %s", rsp_count, msg);
   endtask

   task automatic send_item(ellipse_req_type r);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= r.op;
      req_plane_axis  <= r.axis;
      req_center_u    <= r.cu;
      req_center_v    <= r.cv;
      req_plane_index <= r.pw;
      req_radius_u    <= r.ru;
      req_radius_v    <= r.rv;
      do @(posedge clock); while (req_stall);
      predict_spans(r);
      if (r.typed) spans_due.push_back(r.want);
      else foreach (predicted[i]) spans_due.push_back(predicted[i]);
      items_sent++;
   endtask

   // hold the sender off until every span owed so far has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (spans_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_span(span_type got);
      span_type w;
      if (spans_due.size() == 0) begin
         report_mismatch("result with no item waiting for it");
         return;
      end
      w = spans_due.pop_front();
      if (got.span_valid !== w.span_valid)
         report_mismatch($sformatf("span_valid got %0d expected %0d", got.span_valid,
                                   w.span_valid));
      if (got.axis !== w.axis)
         report_mismatch($sformatf("span_axis got %0d expected %0d", got.axis, w.axis));
      if (got.u_lo !== w.u_lo)
         report_mismatch($sformatf("span_u_lo got %0d expected %0d", got.u_lo, w.u_lo));
      if (got.u_hi !== w.u_hi)
         report_mismatch($sformatf("span_u_hi got %0d expected %0d", got.u_hi, w.u_hi));
      if (got.row !== w.row)
         report_mismatch($sformatf("span_row got %0d expected %0d", got.row, w.row));
      if (got.plane !== w.plane)
         report_mismatch($sformatf("span_plane got %0d expected %0d", got.plane, w.plane));
      if (got.last !== w.last)
         report_mismatch($sformatf("last_span got %0d expected %0d", got.last, w.last));
   endtask

   // result side: random stall before each item, quiet stretches now and then
   initial begin
      int       hold;
      span_type got;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_quiet = ($urandom_range(0, 2) == 0);
         hold = receiver_quiet ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_span_valid, rsp_span_axis, rsp_span_u_lo, rsp_span_u_hi, rsp_span_row,
                 rsp_span_plane, rsp_last_span};
         check_span(got);
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int              item_target;
      int              cap;
      int              cnt;
      // idle next items, single-cell jobs at the coordinate extremes
      stim_rows.push_back(mk_typed(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0), '0));
      stim_rows.push_back(mk_typed(mk_row(OP_START, 3, -2048, 2047, 2047, 0, 0),
         span_type'{1'b1, 2'd3, -13'sd2048, -13'sd2048, 13'sd2047, 12'sd2047, 1'b1}));
      stim_rows.push_back(mk_typed(mk_row(OP_NEXT, 3, -1, -1, -1, 1023, 1023), '0));
      stim_rows.push_back(mk_typed(mk_row(OP_START, 0, 2047, -2048, -2048, 0, 0),
         span_type'{1'b1, 2'd0, 13'sd2047, 13'sd2047, -13'sd2048, -12'sd2048, 1'b1}));
      // small ellipses run to completion, the first with one more next after it
      stim_rows.push_back(mk_row(OP_START, 1, 10, -7, 5, 3, 2));
      repeat (3) stim_rows.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0));
      stim_rows.push_back(mk_row(OP_START, 2, -100, 200, -1, 2, 5));
      repeat (4) stim_rows.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0));
      // full radii, wrapped coordinates, starts that drop an active job
      stim_rows.push_back(mk_row(OP_START, 1, 2047, 2047, 0, 1023, 1023));
      stim_rows.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0));
      stim_rows.push_back(mk_row(OP_START, 0, -2048, -2048, 1, 1023, 0));
      stim_rows.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0));
      stim_rows.push_back(mk_row(OP_START, 3, 0, 0, 0, 0, 1023));
      stim_rows.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0));
      stim_rows.push_back(mk_row(OP_START, 2, 1, -1, 7, 1, 0));
      repeat (2) stim_rows.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0));

      do @(posedge clock); while (reset);
      foreach (stim_rows[i]) send_item(stim_rows[i]);
      wait_drained();

      item_target = items_sent + RANDOM_ITEMS;
      while (items_sent < item_target) begin
         sender_quiet = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0: wait_drained();
            1: send_item(rand_row(OP_NEXT));
            default: begin
               send_item(rand_row(OP_START));
               // big radii run for hundreds of iterations, so cut those short
               cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 40;
               cnt = 0;
               while (job_busy && cnt < cap) begin
                  send_item(rand_row(OP_NEXT));
                  cnt++;
               end
               if ($urandom_range(0, 3) == 0) send_item(rand_row(OP_NEXT));
            end
         endcase
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (spans_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
